FILE: rtl/core/rmq_pkg.sv
// rmq_pkg: shared types, widths and helpers for the matrix to quaternion pipeline
// no dependencies; imported by rmq_sqrt, rmq_div, rotation_matrix_to_quaternion, checker and test

package rmq_pkg;

   // fixed point format of every element and component
   localparam int FRAC_BITS  = 14;
   localparam int ELEM_W     = 16;
   localparam int SUM_W      = ELEM_W + 1;
   localparam int RAD_T_W    = ELEM_W + 3;
   localparam int RAD_W      = 32;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int MAG_W      = SUM_W;
   localparam int REM_W      = ROOT_W + 3;
   localparam int QUO_W      = 16;
   localparam int NUM_W      = 32;
   localparam int DEN_W      = ROOT_W + 1;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = QUO_W;

   localparam logic signed [RAD_T_W-1:0] ONE = RAD_T_W'(1) <<< FRAC_BITS;

   localparam logic [QUO_W-1:0] SAT_POS = 16'h7fff;
   localparam logic [QUO_W-1:0] SAT_NEG = 16'h8000;

   // component that takes the root directly
   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2,
      AXIS_W = 2'd3
   } axis_type;

   // status that leaves a divider lane with its quotient
   typedef struct packed {
      logic ovf;
      logic zero;
      logic neg;
   } div_flags_type;

   // one divider lane operand: sign and magnitude of the numerator
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } lane_type;

   // sideband that rides through the square root
   typedef struct packed {
      axis_type axis;
      lane_type lane0;
      lane_type lane1;
      lane_type lane2;
   } side_type;

   function automatic logic signed [SUM_W-1:0] sx_sum(input logic signed [ELEM_W-1:0] v);
      sx_sum = SUM_W'(v);
   endfunction

   function automatic logic signed [RAD_T_W-1:0] sx_rad(input logic signed [ELEM_W-1:0] v);
      sx_rad = RAD_T_W'(v);
   endfunction

   // split a signed sum into sign and magnitude
   function automatic lane_type to_lane(input logic signed [SUM_W-1:0] d);
      lane_type l;
      l.neg = d[SUM_W-1];
      l.mag = l.neg ? MAG_W'(-d) : MAG_W'(d);
      to_lane = l;
   endfunction

endpackage

FILE: rtl/core/rotation_matrix_to_quaternion.sv
// rotation_matrix_to_quaternion: 3x3 rotation matrix to quaternion, fully pipelined
// rsp_valid follows start through the input, trace, square root, divider and output registers
// throughput: one matrix per cycle; busy is always low and results never stall
// the 16-stage square root and the three 16-stage divider lanes set the depth
// synchronous reset clears every valid bit; payload registers are not reset
// depends on rmq_pkg, rmq_sqrt, rmq_div

module rotation_matrix_to_quaternion
   import rmq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_m00,
   input  logic signed [15:0] req_m01,
   input  logic signed [15:0] req_m02,
   input  logic signed [15:0] req_m10,
   input  logic signed [15:0] req_m11,
   input  logic signed [15:0] req_m12,
   input  logic signed [15:0] req_m20,
   input  logic signed [15:0] req_m21,
   input  logic signed [15:0] req_m22,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_qx,
   output logic signed [15:0] rsp_qy,
   output logic signed [15:0] rsp_qz,
   output logic signed [15:0] rsp_qw
);

   localparam int SIDE_W = $bits(side_type);
   localparam int DLY    = DIV_STEPS + 1;

   typedef struct packed {
      axis_type          axis;
      logic [ROOT_W-1:0] half;
   } dly_type;

   logic                     a_vld_ff;
   logic signed [ELEM_W-1:0] a_m_ff [9];

   logic                      b_vld_ff;
   logic signed [ELEM_W-1:0]  b_m_ff [9];
   logic signed [SUM_W:0]     b_tr_ff;
   logic                      b_pos_ff;
   axis_type                  b_axis_ff;
   logic signed [SUM_W:0]     tr_in;
   axis_type                  axis_in;

   logic signed [RAD_T_W-1:0] t_c;
   logic signed [SUM_W-1:0]   d0_c, d1_c, d2_c;
   logic [RAD_W-1:0]          rad_c;
   side_type                  side_c;

   logic              sq_vld;
   logic [ROOT_W-1:0] sq_root;
   logic [SIDE_W-1:0] sq_side_bits;
   side_type          sq_side;
   logic [ROOT_W:0]   half_sum;

   logic          dv_vld  [3];
   logic [QUO_W-1:0] dv_quo [3];
   div_flags_type dv_flags [3];
   logic [QUO_W-1:0] lane_q [3];

   dly_type  dly_ff [DLY];
   logic [DLY-1:0] dly_vld_ff;

   logic             rsp_valid_ff;
   logic [QUO_W-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic [QUO_W-1:0] qx_in, qy_in, qz_in, qw_in;

   assign busy = 1'b0;

   // input beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start;
      end
      a_m_ff[0] <= req_m00;
      a_m_ff[1] <= req_m01;
      a_m_ff[2] <= req_m02;
      a_m_ff[3] <= req_m10;
      a_m_ff[4] <= req_m11;
      a_m_ff[5] <= req_m12;
      a_m_ff[6] <= req_m20;
      a_m_ff[7] <= req_m21;
      a_m_ff[8] <= req_m22;
   end

   // trace and major diagonal axis
   always_comb begin
      tr_in = (SUM_W+1)'(a_m_ff[0]) + (SUM_W+1)'(a_m_ff[4]) + (SUM_W+1)'(a_m_ff[8]);
      if (a_m_ff[4] > a_m_ff[0]) begin
         axis_in = (a_m_ff[8] > a_m_ff[4]) ? AXIS_Z : AXIS_Y;
      end else begin
         axis_in = (a_m_ff[8] > a_m_ff[0]) ? AXIS_Z : AXIS_X;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
      b_m_ff    <= a_m_ff;
      b_tr_ff   <= tr_in;
      b_pos_ff  <= (tr_in > 0);
      b_axis_ff <= axis_in;
   end

   // radicand and the three numerators for the chosen case
   always_comb begin
      t_c  = RAD_T_W'(b_tr_ff) + ONE;
      d0_c = sx_sum(b_m_ff[7]) - sx_sum(b_m_ff[5]);
      d1_c = sx_sum(b_m_ff[2]) - sx_sum(b_m_ff[6]);
      d2_c = sx_sum(b_m_ff[3]) - sx_sum(b_m_ff[1]);
      side_c.axis = AXIS_W;
      if (!b_pos_ff) begin
         side_c.axis = b_axis_ff;
         case (b_axis_ff)
            AXIS_X: begin
               t_c  = sx_rad(b_m_ff[0]) - (sx_rad(b_m_ff[4]) + sx_rad(b_m_ff[8])) + ONE;
               d0_c = sx_sum(b_m_ff[7]) - sx_sum(b_m_ff[5]);
               d1_c = sx_sum(b_m_ff[3]) + sx_sum(b_m_ff[1]);
               d2_c = sx_sum(b_m_ff[6]) + sx_sum(b_m_ff[2]);
            end
            AXIS_Y: begin
               t_c  = sx_rad(b_m_ff[4]) - (sx_rad(b_m_ff[8]) + sx_rad(b_m_ff[0])) + ONE;
               d0_c = sx_sum(b_m_ff[2]) - sx_sum(b_m_ff[6]);
               d1_c = sx_sum(b_m_ff[7]) + sx_sum(b_m_ff[5]);
               d2_c = sx_sum(b_m_ff[1]) + sx_sum(b_m_ff[3]);
            end
            default: begin
               t_c  = sx_rad(b_m_ff[8]) - (sx_rad(b_m_ff[0]) + sx_rad(b_m_ff[4])) + ONE;
               d0_c = sx_sum(b_m_ff[3]) - sx_sum(b_m_ff[1]);
               d1_c = sx_sum(b_m_ff[2]) + sx_sum(b_m_ff[6]);
               d2_c = sx_sum(b_m_ff[5]) + sx_sum(b_m_ff[7]);
            end
         endcase
      end
      // a negative radicand clamps to zero
      rad_c = t_c[RAD_T_W-1] ? '0
            : RAD_W'({t_c[RAD_T_W-3:0], {FRAC_BITS{1'b0}}});
      side_c.lane0 = to_lane(d0_c);
      side_c.lane1 = to_lane(d1_c);
      side_c.lane2 = to_lane(d2_c);
   end

   rmq_sqrt #(
      .SIDE_W (SIDE_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_vld_ff),
      .in_rad    (rad_c),
      .in_side   (SIDE_W'(side_c)),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side_bits)
   );

   assign sq_side  = side_type'(sq_side_bits);
   assign half_sum = (ROOT_W+1)'(sq_root) + (ROOT_W+1)'(1);

   // three divider lanes
   rmq_div u_div0 (
      .clock (clock), .reset (reset), .in_valid (sq_vld), .in_root (sq_root),
      .in_lane (sq_side.lane0), .out_valid (dv_vld[0]), .out_quo (dv_quo[0]),
      .out_flags (dv_flags[0])
   );
   rmq_div u_div1 (
      .clock (clock), .reset (reset), .in_valid (sq_vld), .in_root (sq_root),
      .in_lane (sq_side.lane1), .out_valid (dv_vld[1]), .out_quo (dv_quo[1]),
      .out_flags (dv_flags[1])
   );
   rmq_div u_div2 (
      .clock (clock), .reset (reset), .in_valid (sq_vld), .in_root (sq_root),
      .in_lane (sq_side.lane2), .out_valid (dv_vld[2]), .out_quo (dv_quo[2]),
      .out_flags (dv_flags[2])
   );

   // root half and axis wait alongside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         dly_vld_ff <= '0;
      end else begin
         dly_vld_ff <= {dly_vld_ff[DLY-2:0], sq_vld};
      end
      dly_ff[0].axis <= sq_side.axis;
      dly_ff[0].half <= half_sum[ROOT_W:1];
      for (int k = 1; k < DLY; k++) begin
         dly_ff[k] <= dly_ff[k-1];
      end
   end

   // sign, saturation and zero root per lane
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (dv_flags[l].zero) begin
            lane_q[l] = '0;
         end else if (dv_flags[l].neg) begin
            lane_q[l] = (dv_flags[l].ovf || dv_quo[l] > SAT_NEG) ? SAT_NEG : QUO_W'(-dv_quo[l]);
         end else begin
            lane_q[l] = (dv_flags[l].ovf || dv_quo[l] > SAT_POS) ? SAT_POS : dv_quo[l];
         end
      end
   end

   // place lanes and root half by axis
   always_comb begin
      case (dly_ff[DLY-1].axis)
         AXIS_X: begin
            qx_in = dly_ff[DLY-1].half; qw_in = lane_q[0];
            qy_in = lane_q[1];          qz_in = lane_q[2];
         end
         AXIS_Y: begin
            qy_in = dly_ff[DLY-1].half; qw_in = lane_q[0];
            qz_in = lane_q[1];          qx_in = lane_q[2];
         end
         AXIS_Z: begin
            qz_in = dly_ff[DLY-1].half; qw_in = lane_q[0];
            qx_in = lane_q[1];          qy_in = lane_q[2];
         end
         default: begin
            qw_in = dly_ff[DLY-1].half; qx_in = lane_q[0];
            qy_in = lane_q[1];          qz_in = lane_q[2];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_vld[0];
      end
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      qz_ff <= qz_in;
      qw_ff <= qw_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_qx    = qx_ff;
   assign rsp_qy    = qy_ff;
   assign rsp_qz    = qz_ff;
   assign rsp_qw    = qw_ff;

   // divider lanes run in lockstep
   assert property (@(posedge clock) disable iff (reset)
      dv_vld[0] == dv_vld[1] && dv_vld[0] == dv_vld[2])
      else $error("divider lanes out of step");

   // side delay line lines up with the dividers
   assert property (@(posedge clock) disable iff (reset)
      dly_vld_ff[DLY-1] == dv_vld[0])
      else $error("root half misaligned with quotients");

   // the scalar component, when taken from the root, is never negative
   assert property (@(posedge clock) disable iff (reset)
      dv_vld[0] && dly_ff[DLY-1].axis == AXIS_W |=> !rsp_qw[15])
      else $error("negative scalar from root");

   // nothing leaves the pipe straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat after reset");

endmodule

FILE: rtl/core/rmq_sqrt.sv
// rmq_sqrt: pipelined rounded integer square root, one result bit per stage
// depends on rmq_pkg

module rmq_sqrt
   import rmq_pkg::*;
#(
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);

   logic [RAD_W-1:0]  rad_ff  [SQRT_STEPS+1];
   logic [REM_W-1:0]  rem_ff  [SQRT_STEPS+1];
   logic [ROOT_W-1:0] root_ff [SQRT_STEPS+1];
   logic [SIDE_W-1:0] side_ff [SQRT_STEPS+1];
   logic [SQRT_STEPS:0] vld_ff;

   logic              res_vld_ff;
   logic [ROOT_W-1:0] res_root_ff;
   logic [SIDE_W-1:0] res_side_ff;
   logic [ROOT_W-1:0] res_root_in;

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      rad_ff[0]  <= in_rad;
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      side_ff[0] <= in_side;
   end

   // one digit of the restoring recurrence per stage
   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      always_comb begin
         rem_sh = {rem_ff[g][REM_W-3:0], rad_ff[g][RAD_W-1:RAD_W-2]};
         trial  = REM_W'({root_ff[g], 2'b01});
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[g][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[g][ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g+1] <= 1'b0;
         end else begin
            vld_ff[g+1] <= vld_ff[g];
         end
         rad_ff[g+1]  <= {rad_ff[g][RAD_W-3:0], 2'b00};
         rem_ff[g+1]  <= rem_in;
         root_ff[g+1] <= root_in;
         side_ff[g+1] <= side_ff[g];
      end
   end

   // round to nearest: bump when the remainder exceeds the floor root
   assign res_root_in = (rem_ff[SQRT_STEPS] > REM_W'(root_ff[SQRT_STEPS]))
                      ? root_ff[SQRT_STEPS] + ROOT_W'(1) : root_ff[SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         res_vld_ff <= 1'b0;
      end else begin
         res_vld_ff <= vld_ff[SQRT_STEPS];
      end
      res_root_ff <= res_root_in;
      res_side_ff <= side_ff[SQRT_STEPS];
   end

   assign out_valid = res_vld_ff;
   assign out_root  = res_root_ff;
   assign out_side  = res_side_ff;

endmodule

FILE: rtl/core/rmq_div.sv
// rmq_div: pipelined rounded divide of a scaled numerator by twice the root
// depends on rmq_pkg

module rmq_div
   import rmq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [ROOT_W-1:0] in_root,
   input  lane_type          in_lane,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output div_flags_type     out_flags
);

   logic [NUM_W-1:0]  num_in;
   logic [DEN_W-1:0]  den_in;
   div_flags_type     flags_in;

   logic [NUM_W-1:0]   rem_ff   [DIV_STEPS+1];
   logic [DEN_W-1:0]   den_ff   [DIV_STEPS+1];
   logic [QUO_W-1:0]   quo_ff   [DIV_STEPS+1];
   div_flags_type      flags_ff [DIV_STEPS+1];
   logic [DIV_STEPS:0] vld_ff;

   // numerator mag*2^FRAC_BITS + s gives the half-up rounding
   always_comb begin
      num_in        = NUM_W'({in_lane.mag, {FRAC_BITS{1'b0}}}) + NUM_W'(in_root);
      den_in        = {in_root, 1'b0};
      flags_in.zero = (in_root == '0);
      flags_in.neg  = in_lane.neg;
      flags_in.ovf  = {1'b0, num_in} >= {den_in, {QUO_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      rem_ff[0]   <= num_in;
      den_ff[0]   <= den_in;
      quo_ff[0]   <= '0;
      flags_ff[0] <= flags_in;
   end

   // one quotient bit per stage, most significant first
   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
      logic [NUM_W:0]   dsh;
      logic             take;
      logic [NUM_W-1:0] rem_in;

      always_comb begin
         dsh    = (NUM_W+1)'(den_ff[g]) << (DIV_STEPS - 1 - g);
         take   = {1'b0, rem_ff[g]} >= dsh;
         rem_in = take ? NUM_W'({1'b0, rem_ff[g]} - dsh) : rem_ff[g];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g+1] <= 1'b0;
         end else begin
            vld_ff[g+1] <= vld_ff[g];
         end
         rem_ff[g+1]   <= rem_in;
         den_ff[g+1]   <= den_ff[g];
         quo_ff[g+1]   <= {quo_ff[g][QUO_W-2:0], take};
         flags_ff[g+1] <= flags_ff[g];
      end
   end

   assign out_valid = vld_ff[DIV_STEPS];
   assign out_quo   = quo_ff[DIV_STEPS];
   assign out_flags = flags_ff[DIV_STEPS];

endmodule

FILE: sim/rotation_matrix_to_quaternion_checker.sv
// rotation_matrix_to_quaternion_checker: predicts each quaternion from the accepted matrix
// and compares it with the result beats; depends on rmq_pkg

`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_checker
   import rmq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [15:0] req_m00,
   input  logic signed [15:0] req_m01,
   input  logic signed [15:0] req_m02,
   input  logic signed [15:0] req_m10,
   input  logic signed [15:0] req_m11,
   input  logic signed [15:0] req_m12,
   input  logic signed [15:0] req_m20,
   input  logic signed [15:0] req_m21,
   input  logic signed [15:0] req_m22,
   input  logic               rsp_valid,
   input  logic signed [15:0] rsp_qx,
   input  logic signed [15:0] rsp_qy,
   input  logic signed [15:0] rsp_qz,
   input  logic signed [15:0] rsp_qw,
   output int                 fail_count,
   output int                 pending,
   output int                 quats_seen
);

   typedef struct packed {
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
      logic signed [15:0] qw;
   } quat_type;

   quat_type quat_queue[$];

   // rounded integer square root
   function automatic longint unsigned round_root(input longint unsigned n);
      longint unsigned lo;
      lo = 0;
      while ((lo + 1) * (lo + 1) <= n) lo = lo + 1;
      if (n - lo * lo > lo) lo = lo + 1;
      return lo;
   endfunction

   // d * 2^(FRAC_BITS-1) / s, nearest, ties away from zero
   function automatic longint half_over_root(input longint d, input longint unsigned s);
      longint unsigned mag;
      longint unsigned q;
      if (s == 0) return 0;
      mag = (d < 0) ? -d : d;
      mag = mag << (FRAC_BITS - 1);
      q = (mag * 2 + s) / (s * 2);
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic quat_type predict_quat(input longint m[3][3]);
      longint q[4];
      longint tr;
      longint t;
      longint unsigned s;
      int i;
      int j;
      int k;
      quat_type r;
      tr = m[0][0] + m[1][1] + m[2][2];
      if (tr > 0) begin
         t = tr + (64'sd1 <<< FRAC_BITS);
         s = round_root(longint'(t) << FRAC_BITS);
         q[3] = (s + 1) >> 1;
         q[0] = half_over_root(m[2][1] - m[1][2], s);
         q[1] = half_over_root(m[0][2] - m[2][0], s);
         q[2] = half_over_root(m[1][0] - m[0][1], s);
      end else begin
         // major axis from the largest diagonal, strict compares
         i = 0;
         if (m[1][1] > m[0][0]) i = 1;
         if (m[2][2] > m[i][i]) i = 2;
         j = (i + 1) % 3;
         k = (j + 1) % 3;
         t = m[i][i] - (m[j][j] + m[k][k]) + (64'sd1 <<< FRAC_BITS);
         if (t < 0) t = 0;
         s = round_root(longint'(t) << FRAC_BITS);
         q[i] = (s + 1) >> 1;
         q[3] = half_over_root(m[k][j] - m[j][k], s);
         q[j] = half_over_root(m[j][i] + m[i][j], s);
         q[k] = half_over_root(m[k][i] + m[i][k], s);
      end
      r.qx = clamp16(q[0]);
      r.qy = clamp16(q[1]);
      r.qz = clamp16(q[2]);
      r.qw = clamp16(q[3]);
      return r;
   endfunction

   assign pending = quat_queue.size();

   // watch both channels at the rising edge
   always @(posedge clock) begin
      longint m[3][3];
      quat_type want;
      quat_type got;
      if (reset) begin
         fail_count <= 0;
         quats_seen <= 0;
      end else begin
         if (start && !busy) begin
            m = '{'{req_m00, req_m01, req_m02},
                  '{req_m10, req_m11, req_m12},
                  '{req_m20, req_m21, req_m22}};
            quat_queue.push_back(predict_quat(m));
         end
         if (rsp_valid) begin
            got = '{rsp_qx, rsp_qy, rsp_qz, rsp_qw};
            quats_seen <= quats_seen + 1;
            if (quat_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result beat %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = quat_queue.pop_front();
               if (want !== got) begin
                  if (fail_count < 10)
                     $display("mismatch: expected x %0d y %0d z %0d w %0d, got x %0d y %0d z %0d w %0d",
                              want.qx, want.qy, want.qz, want.qw,
                              got.qx, got.qy, got.qz, got.qw);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: sim/rotation_matrix_to_quaternion_test.sv
// rotation_matrix_to_quaternion_test: stimulus and verdict for the matrix to quaternion block
// depends on rmq_pkg, the block and rotation_matrix_to_quaternion_checker

`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_test;
   import rmq_pkg::*;

   localparam int LATENCY  = 37;
   localparam int WATCHDOG = 2000;
   localparam int ONE_Q    = 1 << FRAC_BITS;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [15:0] mat [9];
   logic rsp_valid;
   logic signed [15:0] rsp_qx, rsp_qy, rsp_qz, rsp_qw;
   int fail_count, pending, quats_seen;
   int idle_cycles = 0;

   initial foreach (mat[n]) mat[n] = '0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   rotation_matrix_to_quaternion u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_m00(mat[0]), .req_m01(mat[1]), .req_m02(mat[2]),
      .req_m10(mat[3]), .req_m11(mat[4]), .req_m12(mat[5]),
      .req_m20(mat[6]), .req_m21(mat[7]), .req_m22(mat[8]),
      .rsp_valid(rsp_valid), .rsp_qx(rsp_qx), .rsp_qy(rsp_qy),
      .rsp_qz(rsp_qz), .rsp_qw(rsp_qw)
   );

   rotation_matrix_to_quaternion_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_m00(mat[0]), .req_m01(mat[1]), .req_m02(mat[2]),
      .req_m10(mat[3]), .req_m11(mat[4]), .req_m12(mat[5]),
      .req_m20(mat[6]), .req_m21(mat[7]), .req_m22(mat[8]),
      .rsp_valid(rsp_valid), .rsp_qx(rsp_qx), .rsp_qy(rsp_qy),
      .rsp_qz(rsp_qz), .rsp_qw(rsp_qw),
      .fail_count(fail_count), .pending(pending), .quats_seen(quats_seen)
   );

   // watchdog on cycles with no beat accepted or returned
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // one matrix beat: present at the falling edge, hold until accepted
   task automatic send_matrix(input logic signed [15:0] v [9]);
      mat = v;
      start <= 1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic gap(input int n);
      start <= 0;
      repeat (n) @(negedge clock);
   endtask

   // near rotation: identity-like axes permuted and signed, plus noise and at times one random element
   task automatic rotation_like(output logic signed [15:0] v [9]);
      int p;
      int sg;
      p = $urandom_range(0, 2);
      foreach (v[n]) v[n] = 16'($signed($urandom_range(0, 4000)) - 2000);
      for (int r = 0; r < 3; r++) begin
         sg = $urandom_range(0, 1) ? 1 : -1;
         v[r * 3 + (r + p) % 3] = 16'(sg * ONE_Q + int'($urandom_range(0, 2000)) - 1000);
      end
      if ($urandom_range(0, 3) == 0) v[$urandom_range(0, 8)] = 16'($urandom);
   endtask

   initial begin
      logic signed [15:0] v [9];
      int sent;
      int burst;
      sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: identity, axis flips, zero matrix, extremes, ties
      v = '{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384}; send_matrix(v);
      v = '{16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, -16'sd16384}; send_matrix(v);
      v = '{-16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, -16'sd16384}; send_matrix(v);
      v = '{-16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, 16'sd16384}; send_matrix(v);
      v = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(v);
      v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
            16'sh7fff, 16'sh7fff, 16'sh7fff}; send_matrix(v);
      v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
            16'sh8000, 16'sh8000, 16'sh8000}; send_matrix(v);
      v = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
            16'sh8000, 16'sh7fff, 16'sh8000}; send_matrix(v);
      v = '{1, 16'sh8000, 16'sh7fff, 16'sh7fff, 0, 16'sh8000, 16'sh8000,
            16'sh7fff, -1}; send_matrix(v);
      v = '{-100, 5, 9, 7, -100, 3, 2, 8, -100}; send_matrix(v);
      v = '{-16'sd8192, 0, 0, 0, -16'sd8192, 0, 0, 0, 16'sd8192}; send_matrix(v);
      v = '{16'sd8192, 0, 0, 0, 16'sd8192, 0, 0, 0, -16'sd20000}; send_matrix(v);
      v = '{0, 16'sd16384, 0, -16'sd16384, 0, 0, 0, 0, 16'sd16384}; send_matrix(v);
      v = '{16'sh7fff, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000}; send_matrix(v);
      v = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
            16'sh7fff, 16'sh7fff, 16'sh8000}; send_matrix(v);
      gap(1);

      // hold off until the pipe drains
      wait (pending == 0);
      @(negedge clock);

      // random bursts, mostly rotation-like matrices
      while (sent < 500) begin
         burst = $urandom_range(1, 20);
         repeat (burst) begin
            if ($urandom_range(0, 4) == 0) foreach (v[n]) v[n] = 16'($urandom);
            else rotation_like(v);
            send_matrix(v);
            sent++;
         end
         if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 8));
      end
      gap(1);

      wait (pending == 0);
      repeat (LATENCY + 5) @(posedge clock);
      $display("sent %0d matrices, %0d quaternions checked, trace and axis branches",
               sent + 15, quats_seen);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/rmq_pkg.sv
rtl/core/rmq_sqrt.sv
rtl/core/rmq_div.sv
rtl/core/rotation_matrix_to_quaternion.sv
sim/rotation_matrix_to_quaternion_checker.sv
sim/rotation_matrix_to_quaternion_test.sv
